/* sv/bresenham_line_rasterizer_assert.svh */
// assertion macros shared by the checker files of the line rasterizer
// no dependencies; every macro expands to one labeled concurrent assertion
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// antecedent in one cycle implies consequent in the next, off during reset
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blr assertion failed");

// same-cycle implication, off during reset
`define BLR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blr assertion failed");

// next-cycle implication that also holds through reset
`define BLR_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("blr assertion failed");

`endif

/* sv/blr_pkg.sv */
// shared types and constants of the line rasterizer
// no dependencies; used by every module of the block
package blr_pkg;

    localparam int COORD_BITS  = 6;               // internal coordinate width, 3 to 6
    localparam int FIELD_W     = 6;               // fixed port width of coordinates
    localparam int INC_S_W     = COORD_BITS + 2;  // 2*minor
    localparam int DEC_W       = COORD_BITS + 3;  // signed decision term
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] t_coord;

    // one classified line, ready for the walker
    typedef struct packed {
        t_coord                   x_start;
        t_coord                   y_start;
        logic                     x_dir_neg;
        logic                     y_dir_neg;
        logic                     y_major;
        t_coord                   major_len;
        logic [INC_S_W-1:0]       inc_straight;
        logic signed [DEC_W-1:0]  inc_diagonal;
        logic signed [DEC_W-1:0]  decision;
    } t_line;

endpackage

/* sv/blr_front.sv */
// front end: classifies a line request into octant, major axis and increments
// depends on blr_pkg
module blr_front (
    input  logic [blr_pkg::FIELD_W-1:0] i_x_start,
    input  logic [blr_pkg::FIELD_W-1:0] i_y_start,
    input  logic [blr_pkg::FIELD_W-1:0] i_x_end,
    input  logic [blr_pkg::FIELD_W-1:0] i_y_end,
    output blr_pkg::t_line              o_line
);
    import blr_pkg::*;

    t_coord xs, ys, xe, ye;
    t_coord dx, dy, maj, mnr;
    logic   x_neg, y_neg, y_maj;
    logic signed [DEC_W-1:0] mnr2, maj1, maj2;

    always_comb begin
        xs    = i_x_start[COORD_BITS-1:0];
        ys    = i_y_start[COORD_BITS-1:0];
        xe    = i_x_end[COORD_BITS-1:0];
        ye    = i_y_end[COORD_BITS-1:0];
        x_neg = xe < xs;
        y_neg = ye < ys;
        dx    = x_neg ? xs - xe : xe - xs;
        dy    = y_neg ? ys - ye : ye - ys;
        // ties go to the x axis
        y_maj = dy > dx;
        maj   = y_maj ? dy : dx;
        mnr   = y_maj ? dx : dy;
        mnr2  = {2'b00, mnr, 1'b0};
        maj1  = {3'b000, maj};
        maj2  = {2'b00, maj, 1'b0};

        o_line.x_start      = xs;
        o_line.y_start      = ys;
        o_line.x_dir_neg    = x_neg;
        o_line.y_dir_neg    = y_neg;
        o_line.y_major      = y_maj;
        o_line.major_len    = maj;
        o_line.inc_straight = {1'b0, mnr, 1'b0};
        o_line.inc_diagonal = mnr2 - maj2;
        o_line.decision     = mnr2 - maj1;
    end

endmodule

/* sv/blr_queue.sv */
// short queue of classified lines between front end and walker
// depends on blr_pkg
module blr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  blr_pkg::t_line i_line,
    output logic           o_full,
    input  logic           i_pop,
    output blr_pkg::t_line o_line,
    output logic           o_empty
);
    import blr_pkg::*;

    t_line             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              wr, rd;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_line  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wp  = wr ? ptr_inc(r_wp) : r_wp;
        n_rp  = rd ? ptr_inc(r_rp) : r_rp;
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_line;
        end
    end

endmodule

/* sv/blr_back.sv */
// back end: walks one line a pixel per cycle, while the output word is free or popped, into a one-word output register
// depends on blr_pkg
module blr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  blr_pkg::t_line              i_line,
    input  logic                        i_line_empty,
    output logic                        o_line_pop,
    output logic [blr_pkg::FIELD_W-1:0] o_point_x,
    output logic [blr_pkg::FIELD_W-1:0] o_point_y,
    output logic                        o_last_point,
    output logic                        o_empty,
    input  logic                        i_pop
);
    import blr_pkg::*;

    logic                    r_busy;
    t_coord                  r_cur_x, r_cur_y, r_steps;
    logic signed [DEC_W-1:0] r_dec;
    logic [INC_S_W-1:0]      r_inc_s;
    logic signed [DEC_W-1:0] r_inc_d;
    logic                    r_x_neg, r_y_neg, r_y_major;
    logic                    r_out_vld;
    t_coord                  r_out_x, r_out_y;
    logic                    r_out_last;

    logic   pop_ok, adv, load, last, diag;
    t_coord step_x, step_y;

    assign pop_ok     = i_pop && r_out_vld;
    assign adv        = r_busy && (!r_out_vld || pop_ok);
    assign load       = !r_busy && !i_line_empty;
    assign o_line_pop = load;
    assign last       = r_steps == '0;
    assign diag       = !r_dec[DEC_W-1];

    always_comb begin
        step_x = r_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        step_y = r_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (adv && last) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (pop_ok) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur_x   <= i_line.x_start;
            r_cur_y   <= i_line.y_start;
            r_steps   <= i_line.major_len;
            r_dec     <= i_line.decision;
            r_inc_s   <= i_line.inc_straight;
            r_inc_d   <= i_line.inc_diagonal;
            r_x_neg   <= i_line.x_dir_neg;
            r_y_neg   <= i_line.y_dir_neg;
            r_y_major <= i_line.y_major;
        end else if (adv && !last) begin
            // major axis always steps, minor axis only on a diagonal step
            if (r_y_major || diag) begin
                r_cur_y <= step_y;
            end
            if (!r_y_major || diag) begin
                r_cur_x <= step_x;
            end
            r_dec   <= diag ? r_dec + r_inc_d : r_dec + $signed({1'b0, r_inc_s});
            r_steps <= r_steps - 1'b1;
        end
        if (adv) begin
            r_out_x    <= r_cur_x;
            r_out_y    <= r_cur_y;
            r_out_last <= last;
        end
    end

    assign o_point_x    = FIELD_W'(r_out_x);
    assign o_point_y    = FIELD_W'(r_out_y);
    assign o_last_point = r_out_last;
    assign o_empty      = !r_out_vld;

endmodule

/* sv/bresenham_line_rasterizer.sv */
// top level of the bresenham line rasterizer, all eight octants
// depends on blr_pkg, blr_front, blr_queue and blr_back
//
// usage:
//   input side is a queue: drive x_start/y_start/x_end/y_end and push; a word
//   is taken on a clock edge with push high and full low.
//   result side is a queue: while empty is low the oldest pixel sits on
//   point_x/point_y/last_point; pop on a clock edge with empty low takes it.
//   a line emits major_len + 1 pixels from start to end, last_point marks
//   the final one; equal end points give a single pixel.
// timing:
//   the front end classifies in the push cycle and writes a two-word queue.
//   the walker loads a line, then emits one pixel per cycle while the
//   output word is free or taken; the walker's single step/decision
//   update loop sets that rate. with an idle walker a pushed line passes
//   the queue entry, the walker registers and the output word in turn.
// reset: synchronous, active low; clears both queues and the walker.
// stalls: with pop low the output word holds and the walker waits; the
//   queue keeps taking lines until both entries are occupied.
module bresenham_line_rasterizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [blr_pkg::FIELD_W-1:0] i_x_start,
    input  logic [blr_pkg::FIELD_W-1:0] i_y_start,
    input  logic [blr_pkg::FIELD_W-1:0] i_x_end,
    input  logic [blr_pkg::FIELD_W-1:0] i_y_end,
    output logic                        empty,
    input  logic                        pop,
    output logic [blr_pkg::FIELD_W-1:0] o_point_x,
    output logic [blr_pkg::FIELD_W-1:0] o_point_y,
    output logic                        o_last_point
);
    import blr_pkg::*;

    t_line front_line, queue_line;
    logic  queue_empty, queue_pop;

    blr_front u_front (
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .o_line    (front_line)
    );

    blr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_line  (front_line),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_line  (queue_line),
        .o_empty (queue_empty)
    );

    blr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line       (queue_line),
        .i_line_empty (queue_empty),
        .o_line_pop   (queue_pop),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_last_point (o_last_point),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

/* sv/blr_checker.sv */
// port-level checker of the line rasterizer, bound to the top level
// depends on blr_pkg and bresenham_line_rasterizer_assert.svh
`include "bresenham_line_rasterizer_assert.svh"

module blr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [blr_pkg::FIELD_W-1:0] o_point_x,
    input logic [blr_pkg::FIELD_W-1:0] o_point_y,
    input logic                        o_last_point
);
    import blr_pkg::*;

    logic [FIELD_W-1:0] r_prev_x, r_prev_y;
    logic               r_prev_last;
    logic               mid_pop, word_held, x_near;

    // output word of the previous cycle
    always_ff @(posedge i_clk) begin
        r_prev_x    <= o_point_x;
        r_prev_y    <= o_point_y;
        r_prev_last <= o_last_point;
    end

    assign mid_pop   = pop && !empty && !o_last_point;
    assign word_held = !empty && (o_point_x == r_prev_x) && (o_point_y == r_prev_y) &&
                       (o_last_point == r_prev_last);
    assign x_near    = (o_point_x == r_prev_x) ||
                       (o_point_x == FIELD_W'(r_prev_x + 1'b1)) ||
                       (o_point_x == FIELD_W'(r_prev_x - 1'b1));

    // nothing to read right after reset
    `BLR_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n, empty)

    // room for a line right after reset
    `BLR_ASSERT_ALWAYS(a_not_full_after_reset, i_clk, !i_rst_n, !full)

    // a waiting word is held until taken
    `BLR_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, !empty && !pop, word_held)

    // inside a line the next pixel follows without a gap
    `BLR_ASSERT_NEXT(a_no_gap_in_line, i_clk, i_rst_n, mid_pop, !empty)

    // successive pixels of one line are neighbors on x
    `BLR_ASSERT_NEXT(a_x_neighbor, i_clk, i_rst_n, mid_pop, x_near)

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_point_x    (o_point_x),
    .o_point_y    (o_point_y),
    .o_last_point (o_last_point)
);
